>>> rtl/sc9p_pkg.sv
// Package for the nine-point star stencil unit: sample and line types, widths,
// and the divide-by-five rounding and saturation function.
// No dependencies; imported by every module of the unit.
package sc9p_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned SMP_W     = 16;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned GRID_W    = 11;
  // Nine 16-bit samples need four more bits to sum without overflow.
  localparam int unsigned SUM_W     = 20;

  // Window geometry: five rows, four of them taken from the line buffer.
  localparam int unsigned LINES     = 4;
  localparam int unsigned WIN       = 5;

  // Grid size limits and reset value.
  localparam int unsigned GRID_MIN      = 5;
  localparam int unsigned GRID_RESET    = 1024;
  localparam int unsigned DEF_MAX_WIDTH = 1024;

  // Reciprocal of five: floor(x * DIV5_MUL / 2**DIV5_SHIFT) equals floor(x / 5)
  // for every x below 2**DIV5_SHIFT.
  localparam int unsigned DIV5_SHIFT = 22;
  localparam int unsigned DIV5_W     = 22;
  localparam logic [DIV5_W-1:0] DIV5_MUL = 22'd838861;

  typedef logic signed [SMP_W-1:0] smp_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // One line buffer entry: the samples of one column in the four older rows,
  // element zero being the oldest row.
  typedef logic [LINES-1:0][SMP_W-1:0] line_t;

  // Divides the stencil sum by five, rounds to nearest and saturates to the
  // signed 16-bit range. Rounding of the magnitude is floor((|s| + 2) / 5).
  function automatic smp_t div5_round_sat(input sum_t s);
    logic [SUM_W-1:0]        mag;
    logic [SUM_W-1:0]        mag_p2;
    logic [SUM_W+DIV5_W-1:0] prod;
    logic [SUM_W-1:0]        q;
    smp_t                    res;
    mag    = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
    mag_p2 = mag + SUM_W'(2);
    prod   = {{DIV5_W{1'b0}}, mag_p2} * {{SUM_W{1'b0}}, DIV5_MUL};
    q      = prod[DIV5_SHIFT +: SUM_W];
    if (!s[SUM_W-1]) begin
      res = (q > SUM_W'(32767)) ? 16'sh7FFF : smp_t'(q[SMP_W-1:0]);
    end else begin
      res = (q >= SUM_W'(32768)) ? 16'sh8000 : smp_t'(-q[SMP_W-1:0]);
    end
    return res;
  endfunction

endpackage

>>> rtl/stencil_2d_cross_9_point_unit.sv
// Top level of the nine-point star stencil unit of radius two.
// Depends on sc9p_pkg and sc9p_line_buf.
//
// Usage: samples of an n-by-n grid stream in row-major order on the input
// channel (in_valid_i / in_stall_o), one beat per sample; frame_start_i on a
// beat places that sample at row 0, column 0. For each sample whose center
// (row-2, col-2) lies two or more cells from every edge, one result beat
// leaves on the output channel (out_valid_o / out_stall_i) carrying the sum
// of the center and its eight star neighbors divided by five, rounded and
// saturated, with the center's row and column. Border centers give no beat.
// The grid side is written through cfg_we_i / cfg_wdata_i while the unit is
// idle and is clamped to the range 5 to MAX_WIDTH.
// Throughput is one sample per cycle while the output is not stalled: each
// sample makes one read and one write of the line buffer, which has one port
// of each kind. A sample reaches the outputs through the stages below.
// Three register stages (input, sum, result) each take a beat whenever they
// are empty or their content moves on, so a stalled receiver holds the result
// and lets the stages behind it fill before in_stall_o rises.
// Reset empties the stages, clears the window and the counters and sets the
// grid side to 1024, or to MAX_WIDTH if smaller; the line buffer needs no clearing.
module stencil_2d_cross_9_point_unit
  import sc9p_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [GRID_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  smp_t              sample_i,
  input  logic              frame_start_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output smp_t              value_o,
  output logic [IDX_W-1:0]  center_row_o,
  output logic [IDX_W-1:0]  center_col_o,
  output logic              frame_last_o
);

  // Counter width holds every column below MAX_WIDTH; NW also holds n itself.
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned NW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned OW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [NW-1:0] N_RESET =
    NW'((GRID_RESET > MAX_WIDTH) ? MAX_WIDTH : GRID_RESET);

  // Configuration: effective grid side.
  logic [NW-1:0] n_q;
  logic [NW-1:0] n_d;
  logic [NW-1:0] n_m1;

  always_comb begin
    if (32'(cfg_wdata_i) < 32'(GRID_MIN)) begin
      n_d = NW'(GRID_MIN);
    end else if (32'(cfg_wdata_i) > 32'(MAX_WIDTH)) begin
      n_d = NW'(MAX_WIDTH);
    end else begin
      n_d = NW'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= N_RESET;
    end else if (cfg_we_i) begin
      n_q <= n_d;
    end
  end

  assign n_m1 = n_q - NW'(1);

  // Pipeline handshake: a stage is free when empty or when its beat moves on.
  logic s1_v_q, s2_v_q, out_v_q;
  logic out_free, s2_adv, s2_free, s1_adv, s1_free, in_acc;

  assign out_free   = !out_v_q || !out_stall_i;
  assign s2_adv     = s2_v_q && out_free;
  assign s2_free    = !s2_v_q || out_free;
  assign s1_adv     = s1_v_q && s2_free;
  assign s1_free    = !s1_v_q || s2_free;
  assign in_stall_o = !s1_free;
  assign in_acc     = in_valid_i && s1_free;

  // Position counters of the next sample.
  logic [CW-1:0] row_q, col_q, row_d, col_d;
  logic [CW-1:0] r_cur, c_cur;
  logic          emit_cur, last_cur;

  always_comb begin
    r_cur = frame_start_i ? '0 : row_q;
    c_cur = frame_start_i ? '0 : col_q;
    if (NW'(c_cur) >= n_m1) begin
      col_d = '0;
      row_d = (NW'(r_cur) >= n_m1) ? '0 : r_cur + CW'(1);
    end else begin
      col_d = c_cur + CW'(1);
      row_d = r_cur;
    end
    emit_cur = (NW'(r_cur) >= NW'(4)) && (NW'(c_cur) >= NW'(4)) &&
               (NW'(r_cur) < n_q) && (NW'(c_cur) < n_q);
    last_cur = (NW'(r_cur) == n_m1) && (NW'(c_cur) == n_m1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_acc) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Input stage: sample, position and flags of the accepted beat.
  smp_t          s1_smp_q;
  logic [CW-1:0] s1_r_q, s1_c_q;
  logic          s1_emit_q, s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_free) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_smp_q  <= sample_i;
      s1_r_q    <= r_cur;
      s1_c_q    <= c_cur;
      s1_emit_q <= emit_cur;
      s1_last_q <= last_cur;
    end
  end

  // Line buffer: read when a beat is accepted, written when it leaves stage one.
  line_t rd_line, wr_line;

  assign wr_line = {smp_t'(s1_smp_q), rd_line[3], rd_line[2], rd_line[1]};

  sc9p_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (c_cur),
    .rd_data_o (rd_line),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_c_q),
    .wr_data_i (wr_line)
  );

  // Window: shifts left by one column as each beat leaves stage one.
  smp_t win_q [WIN][WIN];
  smp_t col_in [WIN];

  always_comb begin
    for (int k = 0; k < LINES; k++) begin
      col_in[k] = smp_t'(rd_line[k]);
    end
    col_in[WIN-1] = s1_smp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WIN; k++) begin
        for (int j = 0; j < WIN; j++) begin
          win_q[k][j] <= '0;
        end
      end
    end else if (s1_adv) begin
      for (int k = 0; k < WIN; k++) begin
        for (int j = 0; j < WIN - 1; j++) begin
          win_q[k][j] <= win_q[k][j+1];
        end
        win_q[k][WIN-1] <= col_in[k];
      end
    end
  end

  // Star sum over the shifted window: center row and center column.
  sum_t sum_d;

  assign sum_d = SUM_W'(win_q[2][1]) + SUM_W'(win_q[2][2]) + SUM_W'(win_q[2][3])
               + SUM_W'(win_q[2][4]) + SUM_W'(col_in[2])
               + SUM_W'(win_q[0][3]) + SUM_W'(win_q[1][3])
               + SUM_W'(win_q[3][3]) + SUM_W'(win_q[4][3]);

  // Center position: two rows and two columns behind the sample.
  logic [OW-1:0] crow_full, ccol_full;

  assign crow_full = OW'(s1_r_q) - OW'(2);
  assign ccol_full = OW'(s1_c_q) - OW'(2);

  // Sum stage: only beats with an interior center stay valid.
  sum_t             s2_sum_q;
  logic [IDX_W-1:0] s2_row_q, s2_col_q;
  logic             s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_free) begin
      s2_v_q <= s1_v_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_sum_q  <= sum_d;
      s2_row_q  <= crow_full[IDX_W-1:0];
      s2_col_q  <= ccol_full[IDX_W-1:0];
      s2_last_q <= s1_last_q;
    end
  end

  // Result stage: divide by five, round and saturate.
  smp_t             value_q;
  logic [IDX_W-1:0] crow_q, ccol_q;
  logic             last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      value_q <= div5_round_sat(s2_sum_q);
      crow_q  <= s2_row_q;
      ccol_q  <= s2_col_q;
      last_q  <= s2_last_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign value_o      = value_q;
  assign center_row_o = crow_q;
  assign center_col_o = ccol_q;
  assign frame_last_o = last_q;

  // The last interior center of a frame lies on the diagonal.
  a_last_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> center_row_o == center_col_o)
    else $error("frame_last on an off-diagonal center");

  // A frame start beat enters stage one at row zero, column zero.
  a_frame_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && frame_start_i |=> s1_r_q == '0 && s1_c_q == '0)
    else $error("frame start did not restart the position counters");

  // A border beat leaving stage one leaves the sum stage empty.
  a_border_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && !s1_emit_q |=> !s2_v_q)
    else $error("border center reached the sum stage");

endmodule

>>> rtl/sc9p_line_buf.sv
// Line buffer of the stencil unit: one entry per column holding four rows,
// with a registered read and forwarding of a write to the same column.
// Depends on sc9p_pkg.
module sc9p_line_buf
  import sc9p_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_MAX_WIDTH,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output line_t         rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  line_t         wr_data_i
);

  line_t mem_q [DEPTH];
  line_t rd_q;
  line_t fwd_data_q;
  logic  fwd_q;

  // Memory write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read; a write to the same column in the same cycle is forwarded.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q       <= mem_q[rd_addr_i];
      fwd_q      <= wr_en_i && (wr_addr_i == rd_addr_i);
      fwd_data_q <= wr_data_i;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

>>> dv/stencil_star_checker.sv
// Checker for the nine-point star stencil unit: follows grid size writes and input
// beats, predicts every result beat and compares the DUT's results field by field.
// Depends on sc9p_pkg for the sample type and the field widths.
`timescale 1ns / 100ps

module stencil_star_checker
  import sc9p_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [GRID_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  smp_t              sample_i,
  input  logic              frame_start_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  smp_t              value_i,
  input  logic [IDX_W-1:0]  center_row_i,
  input  logic [IDX_W-1:0]  center_col_i,
  input  logic              frame_last_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    smp_t             value;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } star_result_t;

  // Predicted results waiting for their beat, oldest first.
  star_result_t      star_q[$];

  // Shadow copy of the unit's state.
  logic [GRID_W-1:0] grid_reg;
  smp_t              line_mem [DEF_MAX_WIDTH][LINES];
  smp_t              win      [WIN][WIN];
  int unsigned       row_pos;
  int unsigned       col_pos;

  // One fifth of the star sum, rounded to nearest and clipped to 16 bits.
  function automatic smp_t star_fifth(int s);
    int q;
    if (s >= 0) begin
      q = (2 * s + 5) / 10;
    end else begin
      q = -((5 - 2 * s) / 10);
    end
    if (q > 32767) begin
      q = 32767;
    end else if (q < -32768) begin
      q = -32768;
    end
    return smp_t'(q);
  endfunction

  // Moves one sample through the line store and the window, queues a result
  // when its center is interior, and advances the raster position.
  function automatic void take_sample(smp_t smp, logic restart);
    int unsigned  n;
    int unsigned  r;
    int unsigned  c;
    smp_t         column [WIN];
    int           sum;
    star_result_t res;
    n = grid_reg;
    if (n < GRID_MIN) n = GRID_MIN;
    if (n > DEF_MAX_WIDTH) n = DEF_MAX_WIDTH;
    if (restart) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;

    // The column of the four older rows leaves the line store; the new sample
    // takes the place of the oldest one.
    for (int k = 0; k < LINES; k++) column[k] = line_mem[c][k];
    for (int k = 0; k + 1 < LINES; k++) line_mem[c][k] = line_mem[c][k + 1];
    line_mem[c][LINES - 1] = smp;
    column[WIN - 1] = smp;

    for (int k = 0; k < WIN; k++) begin
      for (int j = 0; j + 1 < WIN; j++) win[k][j] = win[k][j + 1];
      win[k][WIN - 1] = column[k];
    end

    if (r >= 4 && c >= 4 && r < n && c < n) begin
      sum = 0;
      for (int j = 0; j < WIN; j++) sum += win[2][j];
      sum += win[0][2] + win[1][2] + win[3][2] + win[4][2];
      res.value = star_fifth(sum);
      res.row   = IDX_W'(r - 2);
      res.col   = IDX_W'(c - 2);
      res.last  = (r == n - 1) && (c == n - 1);
      star_q.push_back(res);
    end

    if (col_pos >= n - 1) begin
      col_pos = 0;
      row_pos = (row_pos >= n - 1) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // Result beats are compared before input beats are predicted; a result can
  // never leave at the edge that accepts its own sample.
  always @(posedge clk_i or negedge rst_ni) begin
    star_result_t want;
    if (!rst_ni) begin
      grid_reg = GRID_W'(GRID_RESET);
      row_pos  = 0;
      col_pos  = 0;
      for (int k = 0; k < WIN; k++) begin
        for (int j = 0; j < WIN; j++) win[k][j] = '0;
      end
      star_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (star_q.size() == 0) begin
          $error("result beat at row %0d col %0d with no result expected",
                 center_row_i, center_col_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = star_q.pop_front();
          if (value_i !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, value_i);
            fail_count_o = fail_count_o + 1;
          end
          if (center_row_i !== want.row) begin
            $error("center_row: expected %0d, got %0d", want.row, center_row_i);
            fail_count_o = fail_count_o + 1;
          end
          if (center_col_i !== want.col) begin
            $error("center_col: expected %0d, got %0d", want.col, center_col_i);
            fail_count_o = fail_count_o + 1;
          end
          if (frame_last_i !== want.last) begin
            $error("frame_last: expected %0d, got %0d", want.last, frame_last_i);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        take_sample(sample_i, frame_start_i);
      end
      if (cfg_we_i) begin
        grid_reg = cfg_wdata_i;
      end
    end
    pending_o = star_q.size();
  end

endmodule

>>> dv/tb.sv
// Top of the stencil unit testbench: clock, reset, grid size writes, sample beats
// in raster frames and random stalls, watchdog and final verdict.
// Depends on sc9p_pkg, stencil_2d_cross_9_point_unit and stencil_star_checker.
`timescale 1ns / 100ps

module tb
  import sc9p_pkg::*;
();

  typedef enum int {FILL_RANDOM, FILL_MAX, FILL_MIN, FILL_TINY, FILL_EXTREME} fill_e;

  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned BIG_LIMIT    = 24;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [GRID_W-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  smp_t              sample_i;
  logic              frame_start_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  smp_t              value_o;
  logic [IDX_W-1:0]  center_row_o;
  logic [IDX_W-1:0]  center_col_o;
  logic              frame_last_o;

  int                fail_count;
  int                pending;
  int unsigned       cur_grid;
  bit                in_quiet  = 1'b0;
  bit                out_quiet = 1'b0;
  int unsigned       stall_left = 0;
  int unsigned       idle_cycles = 0;

  stencil_2d_cross_9_point_unit DUT (.*);

  stencil_star_checker star_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .sample_i      (sample_i),
    .frame_start_i (frame_start_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_i       (value_o),
    .center_row_i  (center_row_o),
    .center_col_i  (center_col_o),
    .frame_last_i  (frame_last_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always #5 clk_i = ~clk_i;

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned grid_side(int unsigned v);
    if (v < GRID_MIN) return GRID_MIN;
    if (v > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return v;
  endfunction

  function automatic smp_t make_sample(fill_e fill);
    case (fill)
      FILL_MAX:     return 16'sh7FFF;
      FILL_MIN:     return 16'sh8000;
      FILL_TINY:    return smp_t'(int'($urandom_range(0, 6)) - 3);
      FILL_EXTREME: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default:      return smp_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // Receiver side: random stall bursts unless this stretch runs quiet.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      if (!out_quiet && $urandom_range(0, 2) == 0) begin
        stall_left <= gap_len();
      end
    end
  end

  // Watchdog: too many cycles without any beat on either channel ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("stencil_2d_cross_9_point_unit regression: fail");
      $finish;
    end
  end

  // Holds off the sender until every predicted result has left and the
  // pipeline has emptied of beats that give no result.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_grid(int unsigned v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= GRID_W'(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_grid = v;
  endtask

  // Drives one sample beat from a falling edge and returns at the falling
  // edge after the beat is taken, with valid still high.
  task automatic send_beat(smp_t s, logic fs);
    int unsigned gap;
    gap = (in_quiet || $urandom_range(0, 1) == 0) ? 0 : gap_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_i      <= s;
    frame_start_i <= fs;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // A noisy frame now and then restarts the raster in its middle.
  task automatic send_frame(int unsigned count, logic fs_first, fill_e fill, bit noisy);
    logic fs;
    for (int unsigned i = 0; i < count; i++) begin
      fs = (i == 0) ? fs_first : (noisy && $urandom_range(0, 40) == 0);
      send_beat(make_sample(fill), fs);
    end
  endtask

  initial begin
    int unsigned v;
    int unsigned side;
    int unsigned count;
    int unsigned shrink_at;
    int unsigned style;
    int unsigned random_items;
    bit          broken;
    logic        fs_first;
    fill_e       fill;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    sample_i      = '0;
    frame_start_i = 1'b0;
    cur_grid      = GRID_RESET;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // A side below the minimum clamps to the smallest grid; one full-scale
    // frame there gives its single center, saturated high.
    write_grid(0);
    send_frame(25, 1'b1, FILL_MAX, 1'b0);

    // Widest grid through an over-range side: four full lines and the start of
    // the fifth, then the side shrinks while the frame is still running.
    settle();
    write_grid(2047);
    send_frame(4 * DEF_MAX_WIDTH + 64, 1'b1, FILL_RANDOM, 1'b0);
    settle();
    write_grid(9);
    send_frame(100, 1'b0, FILL_RANDOM, 1'b0);
    broken = 1'b1;

    // Random frames. A frame that did not end cleanly leaves the raster
    // position unknown, so the next one restarts it; the side only grows at
    // a frame boundary so that no line entry is read before it was written.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      in_quiet  = ($urandom_range(0, 5) == 0);
      out_quiet = ($urandom_range(0, 5) == 0);
      fill = $urandom_range(0, 1) ? FILL_RANDOM : fill_e'($urandom_range(0, 4));
      style = $urandom_range(0, 19);
      if (style == 0) begin
        v = $urandom_range(0, GRID_MIN - 1);
      end else if (style == 1) begin
        v = $urandom_range(DEF_MAX_WIDTH, 2047);
      end else if (style < 5) begin
        v = $urandom_range(13, BIG_LIMIT);
      end else begin
        v = $urandom_range(GRID_MIN, 12);
      end
      if (v != cur_grid || $urandom_range(0, 3) == 0) begin
        settle();
        write_grid(v);
      end
      side     = grid_side(cur_grid);
      fs_first = broken || ($urandom_range(0, 3) != 0);
      style    = $urandom_range(0, 9);
      if (side > BIG_LIMIT || style == 0) begin
        // Cut short by the next frame's start.
        count = $urandom_range(1, (side > BIG_LIMIT) ? 300 : side * side - 1);
        send_frame(count, fs_first, fill, 1'b0);
        broken = 1'b1;
      end else if (style == 1) begin
        count = side * side;
        send_frame(count, fs_first, fill, 1'b1);
        broken = 1'b1;
      end else if (style == 2 && side > GRID_MIN) begin
        // The side shrinks while the counters keep running.
        shrink_at = $urandom_range(side, side * side - 1);
        send_frame(shrink_at, fs_first, fill, 1'b0);
        settle();
        write_grid($urandom_range(0, side - 1));
        count = $urandom_range(1, 2 * grid_side(cur_grid) * grid_side(cur_grid));
        send_frame(count, 1'b0, fill, 1'b0);
        count  = count + shrink_at;
        broken = 1'b1;
      end else begin
        count = side * side;
        send_frame(count, fs_first, fill, 1'b0);
        broken = 1'b0;
      end
      random_items = random_items + count;
    end

    in_quiet  = 1'b0;
    out_quiet = 1'b0;
    settle();
    if (fail_count == 0) begin
      $display("stencil_2d_cross_9_point_unit regression: pass");
    end else begin
      $display("stencil_2d_cross_9_point_unit regression: fail");
    end
    $finish;
  end

endmodule
